@@ rtl/core/edf_pkg.sv @@
// shared types, constants and codes of the deadline scheduler
package edf_pkg;

    // table size and the widths that follow from it
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // opcodes
    localparam logic [1:0] OP_RELEASE  = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_COUNTS   = 2'd2;
    localparam logic [1:0] OP_IGNORED  = 2'd3;

    // release kinds
    localparam logic PERIODIC  = 1'b0;
    localparam logic APERIODIC = 1'b1;

    // event codes
    localparam logic [2:0] EV_RELEASED = 3'd0;
    localparam logic [2:0] EV_ON_TIME  = 3'd1;
    localparam logic [2:0] EV_OVERDUE  = 3'd2;
    localparam logic [2:0] EV_COUNTS   = 3'd3;
    localparam logic [2:0] EV_FULL     = 3'd4;
    localparam logic [2:0] EV_EMPTY    = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  user_task;
        logic        aperiodic;
        logic [31:0] job_id;
        logic [31:0] release_tick;
        logic [31:0] deadline_tick;
        logic [31:0] finish_tick;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  event_task;
        logic [31:0] event_tick;
        logic        head_valid;
        logic [31:0] head_job;
        logic [7:0]  head_task;
        logic        head_first_start;
        logic        demote_valid;
        logic [31:0] demote_job;
        logic [4:0]  active_total;
        logic [15:0] on_time_total;
        logic [15:0] overdue_total;
    } t_out_word;

    // one table entry
    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] job;
        logic        started;
        logic        aper;
        logic [7:0]  task_tag;
    } t_entry;

    typedef enum logic [1:0] {
        A_ZERO,
        A_ONE,
        A_PTR,
        A_PTRM1
    } t_addr_sel;

    typedef enum logic [1:0] {
        W_RDATA,
        W_NEW,
        W_STARTED
    } t_wdata_sel;

    typedef enum logic [2:0] {
        P_HOLD,
        P_FILL,
        P_ONE,
        P_INC,
        P_DEC
    } t_ptr_op;

    typedef enum logic [2:0] {
        E_FULL,
        E_EMPTY,
        E_COUNTS,
        E_RELEASED,
        E_DONE
    } t_ev_sel;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       rd_en;
        t_addr_sel  rd_sel;
        logic       wr_en;
        t_addr_sel  wr_sel;
        t_wdata_sel wd_sel;
        t_ptr_op    ptr_op;
        logic       fill_inc;
        logic       fill_dec;
        logic       ev_set;
        t_ev_sel    ev_sel;
        logic       head_clear;
        logic       head_capture;
        logic       first_capture;
        logic       demote_capture;
        logic       out_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       aperiodic;
        logic       fill_full;
        logic       fill_zero;
        logic       fill_gt1;
        logic       ptr_zero;
        logic       ptr_ge_fill;
        logic       scan_pred;
        logic       out_free;
    } t_dp_status;

endpackage

@@ rtl/core/edf_deadline_scheduler_core.sv @@
// earliest-deadline-first scheduler top level: controller plus table datapath
// per word: counts, full and empty words go from decode to the head read and out; a periodic
//   release first moves later entries up one slot, a completion moves every entry down one slot
// throughput: one word at a time, the next taken the cycle after the result is loaded;
//   a table walk goes one entry at a time through the registered read port
// reset: synchronous, active low; clears controller, fill, counts and output valid, not the table
module edf_deadline_scheduler_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  edf_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output edf_pkg::t_out_word o_out_word
);
    import edf_pkg::*;

    // command and status between the two halves
    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // controller: decodes the latched word and steps the table walks
    edf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    // datapath: table memory, walk pointer, counts and the output register
    // the output register lets a new word in while the last result waits
    edf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

@@ rtl/core/edf_dpath.sv @@
// deadline scheduler datapath: task table, pointer, counters, result and output registers
module edf_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  edf_pkg::t_in_word  i_in_word,
    input  edf_pkg::t_ctrl_cmd i_cmd,
    output edf_pkg::t_dp_status o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output edf_pkg::t_out_word o_out_word
);
    import edf_pkg::*;

    t_entry             r_mem [TABLE_DEPTH];
    t_entry             r_rdata;
    t_in_word           r_in;
    logic [CNT_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   r_fill;
    logic [15:0]        r_on_time;
    logic [15:0]        r_overdue;
    logic [2:0]         r_ev_res;
    logic [7:0]         r_ev_task;
    logic [31:0]        r_ev_tick;
    logic               r_head_valid;
    logic [31:0]        r_head_job;
    logic [7:0]         r_head_task;
    logic               r_first;
    logic               r_dem_valid;
    logic [31:0]        r_dem_job;
    logic               r_out_valid;
    t_out_word          r_out;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [CNT_W-1:0]   ptr_m1;
    t_entry             wr_data;
    logic               on_time;

    function automatic logic [IDX_W-1:0] pick_addr(t_addr_sel sel, logic [CNT_W-1:0] ptr,
                                                   logic [CNT_W-1:0] ptrm1);
        logic [IDX_W-1:0] a;
        case (sel)
            A_ZERO:  a = '0;
            A_ONE:   a = IDX_W'(1);
            A_PTR:   a = ptr[IDX_W-1:0];
            A_PTRM1: a = ptrm1[IDX_W-1:0];
            default: a = '0;
        endcase
        return a;
    endfunction

    assign ptr_m1  = r_ptr - CNT_W'(1);
    assign rd_addr = pick_addr(i_cmd.rd_sel, r_ptr, ptr_m1);
    assign wr_addr = pick_addr(i_cmd.wr_sel, r_ptr, ptr_m1);
    assign on_time = (r_in.finish_tick <= r_rdata.deadline);

    always_comb begin
        case (i_cmd.wd_sel)
            W_NEW: begin
                wr_data.deadline = r_in.deadline_tick;
                wr_data.job      = r_in.job_id;
                wr_data.started  = 1'b0;
                wr_data.aper     = r_in.aperiodic;
                wr_data.task_tag = r_in.user_task;
            end
            W_STARTED: begin
                wr_data         = r_rdata;
                wr_data.started = 1'b1;
            end
            default: wr_data = r_rdata;
        endcase
    end

    // task table, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // input latch and walk pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_word;
        end
        case (i_cmd.ptr_op)
            P_FILL:  r_ptr <= r_fill;
            P_ONE:   r_ptr <= CNT_W'(1);
            P_INC:   r_ptr <= r_ptr + CNT_W'(1);
            P_DEC:   r_ptr <= ptr_m1;
            default: r_ptr <= r_ptr;
        endcase
    end

    // fill and saturating completion counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_on_time <= '0;
            r_overdue <= '0;
        end else begin
            if (i_cmd.fill_inc) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (i_cmd.fill_dec) begin
                r_fill <= r_fill - CNT_W'(1);
            end
            if (i_cmd.ev_set && i_cmd.ev_sel == E_DONE) begin
                if (on_time && r_on_time != '1) begin
                    r_on_time <= r_on_time + 16'd1;
                end
                if (!on_time && r_overdue != '1) begin
                    r_overdue <= r_overdue + 16'd1;
                end
            end
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_set) begin
            case (i_cmd.ev_sel)
                E_FULL: begin
                    r_ev_res  <= EV_FULL;
                    r_ev_task <= r_in.user_task;
                    r_ev_tick <= r_in.release_tick;
                end
                E_EMPTY: begin
                    r_ev_res  <= EV_EMPTY;
                    r_ev_task <= '0;
                    r_ev_tick <= r_in.finish_tick;
                end
                E_RELEASED: begin
                    r_ev_res  <= EV_RELEASED;
                    r_ev_task <= r_in.user_task;
                    r_ev_tick <= r_in.release_tick;
                end
                E_DONE: begin
                    r_ev_res  <= on_time ? EV_ON_TIME : EV_OVERDUE;
                    r_ev_task <= r_rdata.task_tag;
                    r_ev_tick <= r_in.finish_tick;
                end
                default: begin
                    r_ev_res  <= EV_COUNTS;
                    r_ev_task <= '0;
                    r_ev_tick <= '0;
                end
            endcase
        end
        if (i_cmd.head_clear) begin
            r_head_valid <= 1'b0;
            r_head_job   <= '0;
            r_head_task  <= '0;
            r_first      <= 1'b0;
            r_dem_valid  <= 1'b0;
            r_dem_job    <= '0;
        end else begin
            if (i_cmd.head_capture) begin
                r_head_valid <= 1'b1;
                r_head_job   <= r_rdata.job;
                r_head_task  <= r_rdata.task_tag;
            end
            if (i_cmd.first_capture) begin
                r_first <= !r_rdata.started;
            end
            if (i_cmd.demote_capture && r_rdata.started) begin
                r_dem_valid <= 1'b1;
                r_dem_job   <= r_rdata.job;
            end
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.event_res        <= r_ev_res;
            r_out.event_task       <= r_ev_task;
            r_out.event_tick       <= r_ev_tick;
            r_out.head_valid       <= r_head_valid;
            r_out.head_job         <= r_head_job;
            r_out.head_task        <= r_head_task;
            r_out.head_first_start <= r_first;
            r_out.demote_valid     <= r_dem_valid;
            r_out.demote_job       <= r_dem_job;
            r_out.active_total     <= 5'(r_fill);
            r_out.on_time_total    <= r_on_time;
            r_out.overdue_total    <= r_overdue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign o_status.opcode      = r_in.opcode;
    assign o_status.aperiodic   = r_in.aperiodic;
    assign o_status.fill_full   = (r_fill >= CNT_W'(TABLE_DEPTH));
    assign o_status.fill_zero   = (r_fill == '0);
    assign o_status.fill_gt1    = (r_fill > CNT_W'(1));
    assign o_status.ptr_zero    = (r_ptr == '0);
    assign o_status.ptr_ge_fill = (r_ptr >= r_fill);
    assign o_status.scan_pred   = r_rdata.aper || (r_rdata.deadline > r_in.deadline_tick);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

endmodule

@@ rtl/core/edf_ctrl.sv @@
// deadline scheduler controller: sequences the table walks for each word
module edf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  edf_pkg::t_dp_status i_status,
    output edf_pkg::t_ctrl_cmd  o_cmd
);
    import edf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_INS_WR,
        S_CMP_EV,
        S_SH_RD,
        S_SH_WR,
        S_HEAD_RD,
        S_HEAD_EV,
        S_DEM_EV,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_sched;
    logic   n_sched;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_sched = r_sched;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_sched = 1'b0;
                unique case (i_status.opcode)
                    OP_RELEASE: begin
                        if (i_status.fill_full) begin
                            o_cmd.ev_set = 1'b1;
                            o_cmd.ev_sel = E_FULL;
                            n_state      = S_HEAD_RD;
                        end else begin
                            o_cmd.ptr_op = P_FILL;
                            n_state = (i_status.aperiodic == APERIODIC) ? S_INS_WR : S_SCAN_RD;
                        end
                    end
                    OP_COMPLETE: begin
                        if (i_status.fill_zero) begin
                            o_cmd.ev_set = 1'b1;
                            o_cmd.ev_sel = E_EMPTY;
                            n_state      = S_HEAD_RD;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = A_ZERO;
                            n_state      = S_CMP_EV;
                        end
                    end
                    OP_COUNTS: begin
                        o_cmd.ev_set = 1'b1;
                        o_cmd.ev_sel = E_COUNTS;
                        n_state      = S_HEAD_RD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            // walk back from the tail, moving later entries up one slot
            S_SCAN_RD: begin
                if (i_status.ptr_zero) begin
                    n_state = S_INS_WR;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_PTRM1;
                    n_state      = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (i_status.scan_pred) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = A_PTR;
                    o_cmd.wd_sel = W_RDATA;
                    o_cmd.ptr_op = P_DEC;
                    n_state      = S_SCAN_RD;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = A_PTR;
                o_cmd.wd_sel   = W_NEW;
                o_cmd.fill_inc = 1'b1;
                o_cmd.ev_set   = 1'b1;
                o_cmd.ev_sel   = E_RELEASED;
                n_sched        = 1'b1;
                n_state        = S_HEAD_RD;
            end
            S_CMP_EV: begin
                o_cmd.ev_set = 1'b1;
                o_cmd.ev_sel = E_DONE;
                o_cmd.ptr_op = P_ONE;
                n_state      = S_SH_RD;
            end
            // pop the head: move every entry down one slot
            S_SH_RD: begin
                if (i_status.ptr_ge_fill) begin
                    o_cmd.fill_dec = 1'b1;
                    n_sched        = 1'b1;
                    n_state        = S_HEAD_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_PTR;
                    n_state      = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = A_PTRM1;
                o_cmd.wd_sel = W_RDATA;
                o_cmd.ptr_op = P_INC;
                n_state      = S_SH_RD;
            end
            S_HEAD_RD: begin
                o_cmd.head_clear = 1'b1;
                if (i_status.fill_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = A_ZERO;
                    n_state      = S_HEAD_EV;
                end
            end
            S_HEAD_EV: begin
                o_cmd.head_capture = 1'b1;
                n_state            = S_FINISH;
                if (r_sched) begin
                    o_cmd.first_capture = 1'b1;
                    o_cmd.wr_en         = 1'b1;
                    o_cmd.wr_sel        = A_ZERO;
                    o_cmd.wd_sel        = W_STARTED;
                    if (i_status.fill_gt1) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = A_ONE;
                        n_state      = S_DEM_EV;
                    end
                end
            end
            S_DEM_EV: begin
                o_cmd.demote_capture = 1'b1;
                n_state              = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sched <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sched <= n_sched;
        end
    end

endmodule

@@ rtl/core/edf_checker.sv @@
// port-level checks of the deadline scheduler, bound to the top level
module edf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input edf_pkg::t_out_word i_out_word
);
    import edf_pkg::*;

    // result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("result word dropped or changed while stalled");

    // head reported exactly when the table is not empty
    a_head_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_word.head_valid == (i_out_word.active_total != 5'd0)))
        else $error("head_valid disagrees with active_total");

    // fill never beyond the table size
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_word.active_total <= 5'(TABLE_DEPTH)))
        else $error("active_total beyond table depth");

    // a demotion needs a second entry and a head
    a_demote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.demote_valid |->
            i_out_word.head_valid && (i_out_word.active_total >= 5'd2))
        else $error("demotion without a second entry");

    // words that do not schedule never report a start or demotion
    a_no_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_word.event_res == EV_COUNTS ||
                        i_out_word.event_res == EV_FULL ||
                        i_out_word.event_res == EV_EMPTY) |->
            !i_out_word.head_first_start && !i_out_word.demote_valid)
        else $error("start or demotion on a non-scheduling word");

endmodule

bind edf_deadline_scheduler_core edf_checker u_edf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_word  (o_out_word)
);
